// ===== hdl/b2da_pkg.sv =====
// Package for the binary to decimal ASCII emitter.
// Holds the field widths and character constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b2da_pkg;

    localparam int C_VALUE_W    = 32;
    localparam int C_CHAR_W     = 6;
    localparam int C_NUM_DIGITS = 10;
    localparam int C_BCD_W      = 4 * C_NUM_DIGITS;

    localparam logic [C_CHAR_W-1:0] C_CHAR_ZERO  = 6'd48;
    localparam logic [C_CHAR_W-1:0] C_CHAR_MINUS = 6'd45;

endpackage

`default_nettype wire

// ===== hdl/b2da_if.sv =====
// Valid/ready channel interfaces for the emitter's input and output.
// Depends on b2da_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface b2da_in_if import b2da_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [C_VALUE_W-1:0] value;
    logic                 is_signed;

    modport source (output valid, output value, output is_signed, input ready);
    modport sink   (input valid, input value, input is_signed, output ready);
endinterface

interface b2da_out_if import b2da_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [C_CHAR_W-1:0] character;
    logic                last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/binary_to_decimal_ascii_emitter.sv =====
// The block takes one 32-bit value per transaction, with a flag that reads it as signed, and
// returns its decimal ASCII text one character per output transaction, most significant digit
// first, without leading zeros, with a leading '-' for a negative signed value and last set on
// the final digit. A serial double-dabble unit shifts the value in one bit per cycle, then the
// leading zero digits are dropped one per cycle and the characters are sent one per cycle from
// an output register while the output is ready. The input is not ready until the last
// character of the previous item has been loaded into the output register.
// Depends on b2da_pkg and the channel interfaces in b2da_if.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_ascii_emitter import b2da_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    b2da_in_if.sink    i_in,
    b2da_out_if.source o_out
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_SKIP = 5'b00100,
        S_SIGN = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [C_VALUE_W-1:0] r_bin, n_bin;
    logic [C_BCD_W-1:0]   r_bcd, n_bcd;
    logic [4:0]           r_cnt, n_cnt;
    logic [3:0]           r_left, n_left;
    logic                 r_neg, n_neg;
    logic                 r_out_valid, n_out_valid;
    logic [C_CHAR_W-1:0]  r_out_char, n_out_char;
    logic                 r_out_last, n_out_last;

    logic [C_BCD_W-1:0]   w_adj;
    logic [3:0]           w_top;
    logic                 w_out_free;
    logic                 w_in_neg;

    assign w_top      = r_bcd[C_BCD_W-1 -: 4];
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_in_neg   = i_in.is_signed && i_in.value[C_VALUE_W-1];

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_out_char;
    assign o_out.last      = r_out_last;

    always_comb begin
        for (int k = 0; k < C_NUM_DIGITS; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                w_adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                w_adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_neg   = w_in_neg;
                    n_bin   = w_in_neg ? (~i_in.value + 1'b1) : i_in.value;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = {w_adj[C_BCD_W-2:0], r_bin[C_VALUE_W-1]};
                n_bin = {r_bin[C_VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(C_VALUE_W - 1)) begin
                    n_left  = 4'(C_NUM_DIGITS);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (w_top == 4'd0 && r_left != 4'd1) begin
                    n_bcd  = {r_bcd[C_BCD_W-5:0], 4'd0};
                    n_left = r_left - 4'd1;
                end else begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = C_CHAR_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = C_CHAR_ZERO + {2'b00, w_top};
                    n_out_last  = (r_left == 4'd1);
                    n_bcd       = {r_bcd[C_BCD_W-5:0], 4'd0};
                    n_left      = r_left - 4'd1;
                    if (r_left == 4'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_cnt      <= n_cnt;
        r_left     <= n_left;
        r_neg      <= n_neg;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    a_conv_to_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV && r_cnt == 5'(C_VALUE_W - 1)) |=> (r_state == S_SKIP))
        else $error("Conversion did not end after the last bit.");

    a_emit_digit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (w_top <= 4'd9 && r_left != 4'd0))
        else $error("Emitted digit is not a decimal digit.");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_char == C_CHAR_MINUS) |-> !r_out_last)
        else $error("Sign character carries the last mark.");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free && r_left == 4'd1)
            |=> (r_state == S_IDLE && r_out_valid && r_out_last))
        else $error("Final digit did not return the block to idle.");

endmodule

`default_nettype wire

// ===== test/tb_binary_to_decimal_ascii_emitter.sv =====
// Self-checking testbench for binary_to_decimal_ascii_emitter: drives signed and unsigned values
// and checks every output character and last flag against a predicted decimal text.
// Depends on b2da_pkg, the channel interfaces in b2da_if and the emitter RTL.
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii_emitter;
    import b2da_pkg::*;

    localparam int unsigned DEC_BASE   = 10;
    localparam int          IDLE_LIMIT = 3000;
    localparam int          DRAIN_WAIT = 60;
    localparam int          PHASE_ITEMS = 98;

    typedef struct packed {
        logic [C_CHAR_W-1:0] character;
        logic                last;
    } t_text_char;

    class decimal_text_board;
        t_text_char pending_chars[$];
        int         mismatches;
        int         values_seen;
        int         negatives_seen;
        int         chars_checked;

        function new();
            mismatches     = 0;
            values_seen    = 0;
            negatives_seen = 0;
            chars_checked  = 0;
        endfunction

        function void note_value(logic [C_VALUE_W-1:0] value, logic is_signed);
            logic                 negative;
            logic [C_VALUE_W-1:0] magnitude;
            int unsigned          digits[C_NUM_DIGITS];
            int                   num_digits;
            t_text_char           ch;
            negative   = is_signed && value[C_VALUE_W-1];
            magnitude  = negative ? -value : value;
            num_digits = 0;
            do begin
                digits[num_digits] = magnitude % DEC_BASE;
                magnitude          = magnitude / DEC_BASE;
                num_digits++;
            end while (magnitude != 0);
            if (negative) begin
                ch.character = C_CHAR_MINUS;
                ch.last      = 1'b0;
                pending_chars.push_back(ch);
                negatives_seen++;
            end
            for (int i = num_digits - 1; i >= 0; i--) begin
                ch.character = C_CHAR_ZERO + C_CHAR_W'(digits[i]);
                ch.last      = (i == 0);
                pending_chars.push_back(ch);
            end
            values_seen++;
        endfunction

        function void check_char(logic [C_CHAR_W-1:0] character, logic last);
            t_text_char want;
            chars_checked++;
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected character %0d last %0b with nothing pending",
                         $time, character, last);
                mismatches++;
                return;
            end
            want = pending_chars.pop_front();
            if (character !== want.character) begin
                $display("%0t: character expected %0d actual %0d",
                         $time, want.character, character);
                mismatches++;
            end
            if (last !== want.last) begin
                $display("%0t: last expected %0b actual %0b", $time, want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   idle_cycles;

    decimal_text_board board;

    b2da_in_if  in_if ();
    b2da_out_if out_if ();

    binary_to_decimal_ascii_emitter dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Both channels are sampled on the clock edge before any update of this edge lands.
    initial begin
        out_if.ready <= 1'b0;
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if (rst_n) begin
                if (in_if.valid && in_if.ready) begin
                    board.note_value(in_if.value, in_if.is_signed);
                end
                if (out_if.valid && out_if.ready) begin
                    board.check_char(out_if.character, out_if.last);
                end
                if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                    idle_cycles = 0;
                end else begin
                    idle_cycles++;
                end
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_value(input logic [C_VALUE_W-1:0] value, input logic is_signed);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.value     <= value;
        in_if.is_signed <= is_signed;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct);
        logic [C_VALUE_W-1:0] value;
        logic [C_VALUE_W-1:0] power;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (PHASE_ITEMS) begin
            case ($urandom_range(3))
                0: value = $urandom;
                1: value = $urandom >> $urandom_range(31);
                2: begin
                    power = 1;
                    repeat ($urandom_range(9)) power = power * DEC_BASE;
                    value = power + $urandom_range(2) - 1;
                    if ($urandom_range(1)) value = -value;
                end
                default: value = -C_VALUE_W'($urandom_range(1000));
            endcase
            send_value(value, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        board = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n           <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.value     <= '0;
        in_if.is_signed <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_value(32'd0, 1'b0);
        send_value(32'd0, 1'b1);
        send_value(32'd1, 1'b0);
        send_value(32'd9, 1'b1);
        send_value(32'd10, 1'b0);
        send_value(32'd99, 1'b0);
        send_value(32'd100, 1'b1);
        send_value(32'hFFFF_FFFF, 1'b0);
        send_value(32'hFFFF_FFFF, 1'b1);
        send_value(32'h8000_0000, 1'b1);
        send_value(32'h8000_0000, 1'b0);
        send_value(32'h7FFF_FFFF, 1'b1);
        send_value(32'h7FFF_FFFF, 1'b0);
        send_value(32'd999_999_999, 1'b0);
        send_value(32'd1_000_000_000, 1'b1);
        send_value(32'd4_000_000_000, 1'b0);
        send_value(32'd4_000_000_000, 1'b1);
        send_value(-32'd10, 1'b1);
        send_value(32'd1_000_000, 1'b0);
        send_value(32'hAAAA_5555, 1'b1);

        run_phase(0, 0);
        run_phase(83, 0);
        run_phase(0, 83);
        run_phase(10, 10);
        in_if.valid <= 1'b0;

        while (board.pending_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (board.pending_chars.size() != 0) begin
            $display("%0t: %0d characters never arrived", $time, board.pending_chars.size());
            board.mismatches++;
        end
        $display("Converted %0d values (%0d negative), checked %0d characters,",
                 board.values_seen, board.negatives_seen, board.chars_checked);
        $display("with free flow, sender gaps, receiver stalls and both together.");
        if (board.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/b2da_pkg.sv
hdl/b2da_if.sv
hdl/binary_to_decimal_ascii_emitter.sv
test/tb_binary_to_decimal_ascii_emitter.sv
